FILE: sv/world_to_screen_projection_macros.svh
// Assertion helpers shared by the projection block
`ifndef WORLD_TO_SCREEN_PROJECTION_MACROS_SVH
`define WORLD_TO_SCREEN_PROJECTION_MACROS_SVH

// Same-cycle implication
`define WTSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtsp check failed");

// Next-cycle implication
`define WTSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtsp check failed");

`endif

FILE: sv/wtsp_pkg.sv
package wtsp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 64;
    // clip sums: three floored products plus one element
    localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
    // normalised magnitude is saturated to 2^40
    localparam int NDC_W      = 41;
    localparam int DIVIDEND_W = ACC_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam int HALF_W     = 13;
    localparam int MX_W       = HALF_W + 1 + NDC_W + 1;
    localparam int SUM_W      = MX_W + 1;

    localparam logic [NDC_W:0] NDC_LIMIT = {1'b0, 1'b1, {(NDC_W-1){1'b0}}};

    localparam logic [30:0] MIN_CLIP_W_RESET = 31'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    // configuration register indexes
    localparam logic [1:0] REG_VIEWPORT_WIDTH  = 2'd0;
    localparam logic [1:0] REG_VIEWPORT_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIN_CLIP_W      = 2'd2;

    // input actions
    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_TRANSFORM = 1'b1;

    typedef logic [NDC_W-1:0] ndc_mag_t;

    // saturate a wide screen value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(signed'(32'sh7fffffff));
        lo = SUM_W'(signed'(32'sh80000000));
        if (v > hi)
        begin
            return 32'sh7fffffff;
        end
        else if (v < lo)
        begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: sv/wtsp_matrix_ram.sv
module wtsp_matrix_ram (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);
    import wtsp_pkg::*;

    logic [31:0] mem [16];
    logic [15:0] valid_reg;
    logic [31:0] rdata_reg;
    logic        rvalid_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    // written flags; an unwritten element reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : 32'd0;

endmodule

FILE: sv/wtsp_divider.sv
module wtsp_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [wtsp_pkg::ACC_W-1:0] dividend,
    input  logic [wtsp_pkg::ACC_W-1:0] divisor,
    output logic                       done,
    output wtsp_pkg::ndc_mag_t         quotient
);
    import wtsp_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] sh_reg;
    logic [ACC_W-1:0]      rem_reg;
    logic [ACC_W-1:0]      div_reg;
    logic [NDC_W:0]        q_reg;
    logic                  sat_reg;

    logic [ACC_W:0]        trial;
    logic                  take;
    logic [ACC_W-1:0]      rem_next;
    logic [NDC_W:0]        q_next;

    // one restoring step per cycle
    always_comb
    begin
        trial    = {rem_reg, sh_reg[DIVIDEND_W-1]};
        take     = trial >= {1'b0, div_reg};
        rem_next = take ? ACC_W'(trial - {1'b0, div_reg}) : trial[ACC_W-1:0];
        q_next   = {q_reg[NDC_W-1:0], take};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {dividend, {FRAC_BITS{1'b0}}};
            rem_reg <= '0;
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[DIVIDEND_W-2:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                sat_reg  <= 1'b0;
            end
            else if (busy_reg)
            begin
                // once past the limit the quotient stays clamped
                if (q_next > NDC_LIMIT)
                begin
                    sat_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? NDC_LIMIT[NDC_W-1:0] : q_reg[NDC_W-1:0];

endmodule

FILE: sv/world_to_screen_projection.sv
// Perspective projection of a world point to viewport pixels, signed Q16.16.
// Input channel (in_valid / in_stall): action 0 writes element_index of the
// column-major 4x4 matrix with element_value and gives no result; action 1
// projects (point_x, point_y, point_z) and gives one result.
// Output channel (out_valid / out_stall): visible, screen_x, screen_y.
// Configuration: cfg_we with cfg_index 0 width, 1 height, 2 min_clip_w.
// A load is written into the matrix memory when it is taken. A transform runs
// through multiply-accumulate (12 matrix reads through the registered-read
// memory into one shared 32x32 multiplier), a w check, the bit-serial dividers
// (66 steps and a done flag, x and y side by side), then a scale and a
// saturating add. Points that are not visible skip the divide and the scale.
// One item is worked at a time; in_stall is high while a transform is busy,
// so a new transform is taken only once the last one is through, and loads
// are taken one per cycle while no transform is busy.
// The result sits in an output register; a stalled result holds and blocks
// the completion of the following transform, which keeps in_stall high.
// Reset clears the matrix to zero (per-element written flags), sets the
// viewport to 1024 x 768 and min_clip_w to 0.1; no clearing pass is needed.
`include "world_to_screen_projection_macros.svh"

module world_to_screen_projection (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [3:0]         element_index,
    input  logic signed [31:0] element_value,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               visible,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data
);
    import wtsp_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_SCALE = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [3:0]  cnt_reg;

    logic [13:0] vp_w_reg;
    logic [13:0] vp_h_reg;
    logic [30:0] min_w_reg;

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, cx_reg, cy_reg, w_reg;
    logic        vis_reg;
    logic        negx_reg, negy_reg;
    logic signed [MX_W-1:0] mx_reg, my_reg;

    logic        out_valid_reg;
    logic        visible_reg;
    logic signed [31:0] sx_reg, sy_reg;

    logic        in_xfer;
    logic        out_free;
    logic        load_we;
    logic [3:0]  rd_addr;
    logic [31:0] rd_data;
    logic [3:0]  step_rd, step_acc;
    logic signed [31:0] coord;
    logic signed [PROD_W-1:0] prod_full, prod_sh;
    logic signed [ACC_W-1:0]  acc_sum;
    logic        w_ok;
    logic        div_start;
    logic [ACC_W-1:0] magx, magy;
    logic        div_done_x, div_done_y;
    ndc_mag_t    qx, qy;
    logic signed [NDC_W:0] nx, ny;
    logic [HALF_W-1:0] hw, hh;
    logic signed [SUM_W-1:0] base_x, base_y, sum_x, sum_y;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = state_reg != ST_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign load_we  = in_xfer && action == ACT_LOAD;

    // step = {row, term}; rows give x, y and w, term 3 is the translation
    assign step_rd  = cnt_reg - 4'd1;
    assign step_acc = cnt_reg - 4'd2;

    always_comb
    begin
        rd_addr = {cnt_reg[1:0], cnt_reg[3], cnt_reg[3] | cnt_reg[2]};
        case (step_rd[1:0])
            2'd0:    coord = px_reg;
            2'd1:    coord = py_reg;
            2'd2:    coord = pz_reg;
            default: coord = 32'(signed'(33'sd1 <<< FRAC_BITS));
        endcase
    end

    wtsp_matrix_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (load_we),
        .waddr (element_index),
        .wdata (element_value),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // shared multiplier and floored accumulate
    assign prod_full = $signed(rd_data) * coord;
    assign prod_sh   = prod_reg >>> FRAC_BITS;
    assign acc_sum   = (step_acc[1:0] == 2'd0) ? prod_sh[ACC_W-1:0]
                                               : acc_reg + prod_sh[ACC_W-1:0];

    // visibility and divider operands
    assign w_ok = (w_reg > 0) && (w_reg >= $signed({{(ACC_W-31){1'b0}}, min_w_reg}));
    assign div_start = state_reg == ST_CHECK && w_ok;
    assign magx = cx_reg[ACC_W-1] ? ACC_W'(-cx_reg) : cx_reg;
    assign magy = cy_reg[ACC_W-1] ? ACC_W'(-cy_reg) : cy_reg;

    wtsp_divider u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (magx),
        .divisor  (w_reg),
        .done     (div_done_x),
        .quotient (qx)
    );

    wtsp_divider u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (magy),
        .divisor  (w_reg),
        .done     (div_done_y),
        .quotient (qy)
    );

    // signed normalised values and screen sums
    always_comb
    begin
        nx = negx_reg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ny = negy_reg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        hw = vp_w_reg[13:1];
        hh = vp_h_reg[13:1];
        base_x = $signed(SUM_W'({hw, {FRAC_BITS{1'b0}}}));
        base_y = $signed(SUM_W'({hh, {FRAC_BITS{1'b0}}}));
        sum_x  = base_x + SUM_W'(mx_reg);
        sum_y  = base_y - SUM_W'(my_reg);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer && action == ACT_TRANSFORM)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == 4'd13)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = w_ok ? ST_DIV : ST_SUM;
            ST_DIV:
            begin
                if (div_done_x)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_SUM;
            ST_SUM:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            vp_w_reg      <= 14'd1024;
            vp_h_reg      <= 14'd768;
            min_w_reg     <= MIN_CLIP_W_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= (state_reg == ST_MAC) ? cnt_reg + 4'd1 : 4'd0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_VIEWPORT_WIDTH:  vp_w_reg  <= cfg_data[13:0];
                    REG_VIEWPORT_HEIGHT: vp_h_reg  <= cfg_data[13:0];
                    REG_MIN_CLIP_W:      min_w_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (state_reg == ST_SUM && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
            pz_reg <= point_z;
        end
        if (state_reg == ST_MAC)
        begin
            if (cnt_reg >= 4'd1 && cnt_reg <= 4'd12)
            begin
                prod_reg <= prod_full;
            end
            if (cnt_reg >= 4'd2)
            begin
                acc_reg <= acc_sum;
                if (step_acc[1:0] == 2'd3)
                begin
                    case (step_acc[3:2])
                        2'd0:    cx_reg <= acc_sum;
                        2'd1:    cy_reg <= acc_sum;
                        default: w_reg  <= acc_sum;
                    endcase
                end
            end
        end
        if (state_reg == ST_CHECK)
        begin
            vis_reg  <= w_ok;
            negx_reg <= cx_reg[ACC_W-1];
            negy_reg <= cy_reg[ACC_W-1];
        end
        if (state_reg == ST_SCALE)
        begin
            mx_reg <= $signed({1'b0, hw}) * nx;
            my_reg <= $signed({1'b0, hh}) * ny;
        end
        if (state_reg == ST_SUM && out_free)
        begin
            visible_reg <= vis_reg;
            sx_reg      <= vis_reg ? sat32(sum_x) : 32'sd0;
            sy_reg      <= vis_reg ? sat32(sum_y) : 32'sd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign visible   = visible_reg;
    assign screen_x  = sx_reg;
    assign screen_y  = sy_reg;

    `WTSP_ASSERT_IMP(a_hidden_zero, clk, rst_n, out_valid && !visible, screen_x == 0 && screen_y == 0)
    `WTSP_ASSERT_IMP(a_div_w_pos, clk, rst_n, div_start, w_reg > 0)
    `WTSP_ASSERT_NEXT(a_xform_starts, clk, rst_n, in_xfer && action == ACT_TRANSFORM, state_reg == ST_MAC)
    `WTSP_ASSERT_IMP(a_div_pair, clk, rst_n, div_done_x || div_done_y, div_done_x && div_done_y)

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtsp_pkg::*;

    localparam int  CYCLE_LIMIT    = 2000000;
    localparam int  DRAIN_CYCLES   = 120;
    localparam int  HOLD_CYCLES    = 600;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
    } projection_t;

    // expected projections and the matrix/viewport state behind them
    class projection_scoreboard;
        logic signed [31:0] matrix [16];
        logic [13:0]        vp_width;
        logic [13:0]        vp_height;
        logic [30:0]        min_w;
        projection_t        expected_q [$];
        int                 errors;

        function void init();
            foreach (matrix[i])
                matrix[i] = '0;
            vp_width  = 14'd1024;
            vp_height = 14'd768;
            min_w     = MIN_CLIP_W_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [30:0] data);
            if (index == REG_VIEWPORT_WIDTH)
                vp_width = data[13:0];
            else if (index == REG_VIEWPORT_HEIGHT)
                vp_height = data[13:0];
            else if (index == REG_MIN_CLIP_W)
                min_w = data;
        endfunction

        // floored Q product
        function longint scaled_mul(longint a, longint m);
            return (a * m) >>> FRAC_BITS;
        endfunction

        // c / w in Q format, truncated toward zero, clamped to +-2^40
        function longint ndc_divide(longint c, longint w);
            logic [127:0] mag;
            logic [127:0] quo;
            mag = (c < 0) ? 128'(-c) : 128'(c);
            quo = (mag << FRAC_BITS) / 128'(w);
            if (quo > (128'd1 << 40))
                quo = 128'd1 << 40;
            return (c < 0) ? -longint'(quo) : longint'(quo);
        endfunction

        function logic signed [31:0] clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        endfunction

        function void note_input(logic act, logic [3:0] idx, logic signed [31:0] val,
                                 logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
            longint      cx;
            longint      cy;
            longint      cw;
            longint      hw;
            longint      hh;
            projection_t res;
            if (act == ACT_LOAD)
            begin
                matrix[idx] = val;
                return;
            end
            cx = scaled_mul(px, matrix[0]) + scaled_mul(py, matrix[4])
               + scaled_mul(pz, matrix[8]) + longint'(matrix[12]);
            cy = scaled_mul(px, matrix[1]) + scaled_mul(py, matrix[5])
               + scaled_mul(pz, matrix[9]) + longint'(matrix[13]);
            cw = scaled_mul(px, matrix[3]) + scaled_mul(py, matrix[7])
               + scaled_mul(pz, matrix[11]) + longint'(matrix[15]);
            res = '0;
            // behind the near limit: reported with zero coordinates
            if (cw > 0 && cw >= longint'({33'd0, min_w}))
            begin
                hw = longint'(vp_width >> 1);
                hh = longint'(vp_height >> 1);
                res.visible  = 1'b1;
                res.screen_x = clamp32((hw << FRAC_BITS) + hw * ndc_divide(cx, cw));
                res.screen_y = clamp32((hh << FRAC_BITS) - hh * ndc_divide(cy, cw));
            end
            expected_q.push_back(res);
        endfunction

        function void check_result(logic vis, logic signed [31:0] sx, logic signed [31:0] sy);
            projection_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("result with nothing expected: visible=%0d x=%0d y=%0d", vis, sx, sy);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (vis !== exp_res.visible)
            begin
                $error("visible: expected %0d, got %0d", exp_res.visible, vis);
                errors++;
            end
            if (sx !== exp_res.screen_x)
            begin
                $error("screen_x: expected %0d, got %0d", exp_res.screen_x, sx);
                errors++;
            end
            if (sy !== exp_res.screen_y)
            begin
                $error("screen_y: expected %0d, got %0d", exp_res.screen_y, sy);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               out_valid;
    logic               out_stall;
    logic               visible;
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [30:0]        cfg_data;

    projection_scoreboard sb;
    bit                   hold_req;
    int                   cycles;

    world_to_screen_projection DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .element_index (element_index),
        .element_value (element_value),
        .point_x       (point_x),
        .point_y       (point_y),
        .point_z       (point_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .visible       (visible),
        .screen_x      (screen_x),
        .screen_y      (screen_y),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, the odd long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches and one long hold-off
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 49) == 0)
            begin
                n = $urandom_range(50, 200);
                out_stall <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                out_stall <= (n != 0);
                if (n > 1)
                    repeat (n - 1) @(posedge clk);
            end
        end
    end

    // result transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(visible, screen_x, screen_y);
    end

    task automatic send_item(logic act, logic [3:0] idx, logic signed [31:0] val,
                             logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz);
        int gap;
        in_valid      <= 1'b1;
        action        <= act;
        element_index <= idx;
        element_value <= val;
        point_x       <= px;
        point_y       <= py;
        point_z       <= pz;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(act, idx, val, px, py, pz);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_element(logic [3:0] idx, logic signed [31:0] val);
        send_item(ACT_LOAD, idx, val, $urandom, $urandom, $urandom);
    endtask

    task automatic project_point(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
        send_item(ACT_TRANSFORM, 4'($urandom), $urandom, px, py, pz);
    endtask

    // let the block drain before touching a register
    task automatic wait_quiet();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one write, then cfg_we is dropped again
    task automatic write_reg(logic [1:0] index, logic [30:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(index, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // mostly plausible values, sometimes any 32-bit pattern
    function automatic logic signed [31:0] rand_element();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
    endfunction

    task automatic random_items(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 4)
                load_element(4'($urandom), rand_element());
            else
                project_point(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial
    begin
        int i;
        sb = new();
        sb.init();
        hold_req      = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = ACT_LOAD;
        element_index = '0;
        element_value = '0;
        point_x       = '0;
        point_y       = '0;
        point_z       = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_VIEWPORT_WIDTH;
        cfg_data      = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared matrix: w is zero, never visible
        project_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000);

        // simple perspective: w = z
        load_element(4'd0, 32'sh0001_0000);
        load_element(4'd5, 32'sh0001_0000);
        load_element(4'd11, 32'sh0001_0000);
        project_point(32'sh0005_0000, -32'sh0003_0000, 32'sh000a_0000);
        project_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000);
        project_point(32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000);
        // just under and exactly at the near limit
        project_point(32'sh0001_0000, 32'sh0001_0000, 32'sd6553);
        project_point(32'sh0001_0000, 32'sh0001_0000, 32'sd6554);
        // field extremes, saturating the screen values
        project_point(32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000);
        project_point(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_2000);
        project_point(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
        // element extremes and translation column
        load_element(4'd12, 32'sh7fff_ffff);
        load_element(4'd13, 32'sh8000_0000);
        load_element(4'd15, 32'sh0002_0000);
        project_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        load_element(4'd15, 32'sh8000_0000);
        project_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        load_element(4'd15, 32'sh0001_0000);
        load_element(4'd12, 32'sh0000_0000);
        load_element(4'd13, 32'sh0000_0000);
        project_point(-32'sh0002_0000, 32'sh0004_0000, 32'sh0000_0000);
        random_items(130);

        // smallest viewport, no near limit; unused register index ignored
        wait_quiet();
        write_reg(REG_VIEWPORT_WIDTH, 31'd1);
        write_reg(REG_VIEWPORT_HEIGHT, 31'd1);
        write_reg(REG_MIN_CLIP_W, 31'd0);
        write_reg(REG_UNUSED, 31'h7fff_ffff);
        project_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0000_0000);
        hold_req = 1'b1;
        random_items(150);

        // 8192 x 8192 viewport, highest near limit
        wait_quiet();
        write_reg(REG_VIEWPORT_WIDTH, 31'd8192);
        write_reg(REG_VIEWPORT_HEIGHT, 31'd8192);
        write_reg(REG_MIN_CLIP_W, 31'h7fff_ffff);
        load_element(4'd15, 32'sh7fff_ffff);
        project_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000);
        random_items(120);

        // a few random settings, all register bits exercised
        for (i = 0; i < 3; i++)
        begin
            wait_quiet();
            write_reg(REG_VIEWPORT_WIDTH, 31'($urandom_range(2, 16383)));
            write_reg(REG_VIEWPORT_HEIGHT, 31'($urandom_range(2, 16383)));
            write_reg(REG_MIN_CLIP_W, (i == 0) ? 31'd6554 : 31'($urandom));
            random_items(110);
        end

        wait_quiet();
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/wtsp_pkg.sv
sv/wtsp_matrix_ram.sv
sv/wtsp_divider.sv
sv/world_to_screen_projection.sv
verif/tb.sv
